>>> sv/dgsp_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dgsp_pkg
// Shared types and constants of the dense graph shortest path unit: field
// widths, opcodes, configuration register indexes and the controller states.
// ----------------------------------------------------------------------------
package dgsp_pkg;

	localparam int NODE_FW   = 4;
	localparam int WEIGHT_FW = 20;
	localparam int DIST_W    = 24;
	localparam int COUNT_FW  = 5;
	localparam int CFG_IDX_W = 1;

	localparam logic [DIST_W-1:0]   DIST_MAX       = 24'hFF_FFFF;
	localparam logic [31:0]         NO_EDGE_MARK   = 32'd999999;
	localparam logic [COUNT_FW-1:0] NODE_COUNT_RST = 5'd16;
	localparam logic [NODE_FW-1:0]  SOURCE_RST     = 4'd0;

	localparam logic OP_LOAD  = 1'b0;
	localparam logic OP_QUERY = 1'b1;

	localparam logic [CFG_IDX_W-1:0] CFG_NODE_COUNT  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_SOURCE_NODE = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_INIT,
		ST_RELAX,
		ST_NEXT,
		ST_READ,
		ST_LATCH,
		ST_RESULT
	} state_t;

endpackage

`default_nettype wire

>>> sv/dense_graph_shortest_path_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dense_graph_shortest_path_unit
// Loads edge weights into a weight memory and answers shortest distance
// queries from the configured source by an adjacency matrix Dijkstra search.
// ----------------------------------------------------------------------------
// Each settled node of a query costs one pass over its weight row, one memory
// read per cycle, and that pass also finds the next nearest node. A query
// with source or target out of range answers without a search.
// One item is in work at a time. Reset is asynchronous and clears control
// state; node_count resets to 16 and source_node to 0; weights stay undefined.

module dense_graph_shortest_path_unit
	import dgsp_pkg::*;
#(
	parameter int MAX_NODES   = 16,
	parameter int WEIGHT_BITS = 20
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,

	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [COUNT_FW-1:0]   cfg_data,

	input  wire logic                  req_valid,
	output logic                       req_stall,
	input  wire logic                  op,
	input  wire logic [NODE_FW-1:0]    from_node,
	input  wire logic [NODE_FW-1:0]    to_node,
	input  wire logic [WEIGHT_FW-1:0]  edge_weight,
	input  wire logic [NODE_FW-1:0]    target_node,

	output logic                       rsp_valid,
	input  wire logic                  rsp_stall,
	output logic [DIST_W-1:0]          distance,
	output logic                       reachable
);

	localparam int NODE_W   = $clog2(MAX_NODES);
	localparam int CNT_W    = $clog2(MAX_NODES + 1);
	localparam int WT_DEPTH = MAX_NODES << NODE_W;
	localparam int SUM_W    = ((WEIGHT_BITS > DIST_W) ? WEIGHT_BITS : DIST_W) + 1;

	state_t state_q, state_d;

	logic [COUNT_FW-1:0]    node_count_q;
	logic [NODE_FW-1:0]     source_q;

	logic [WEIGHT_BITS-1:0] wt_mem [WT_DEPTH];
	logic [WEIGHT_BITS-1:0] wt_rdata_s1;
	logic [2*NODE_W-1:0]    wt_waddr;
	logic [2*NODE_W-1:0]    wt_raddr;
	logic                   wt_we;

	logic [DIST_W-1:0]      dist_mem [MAX_NODES];
	logic [DIST_W-1:0]      dist_rdata_s1;
	logic [NODE_W-1:0]      dist_waddr;
	logic [NODE_W-1:0]      dist_raddr;
	logic [DIST_W-1:0]      dist_wdata;
	logic                   dist_we;

	logic [MAX_NODES-1:0]   reached_q;
	logic [MAX_NODES-1:0]   done_q;
	logic [NODE_W-1:0]      u_q;
	logic [DIST_W-1:0]      best_q;
	logic [NODE_W-1:0]      v_q;
	logic [CNT_W-1:0]       n_q;
	logic [NODE_W-1:0]      tgt_q;
	logic                   found_q;
	logic [DIST_W-1:0]      min_q;
	logic [NODE_W-1:0]      mi_q;
	logic [NODE_W-1:0]      v_s1;
	logic                   vld_s1;
	logic [DIST_W-1:0]      res_dist_q;
	logic                   res_ok_q;
	logic                   rsp_valid_q;
	logic [DIST_W-1:0]      distance_q;
	logic                   reachable_q;

	logic [CNT_W-1:0]       n_eff;
	logic                   query_ok;
	logic                   load_ok;
	logic                   accept;
	logic                   out_load;
	logic                   v_last;

	logic [SUM_W-1:0]       sum;
	logic [DIST_W-1:0]      cand;
	logic                   edge_ok;
	logic                   open_v;
	logic                   upd;
	logic [DIST_W-1:0]      new_d;
	logic                   new_reach;
	logic                   found_c;
	logic [DIST_W-1:0]      min_c;
	logic [NODE_W-1:0]      mi_c;

	assign n_eff = (32'(node_count_q) > 32'(MAX_NODES)) ? CNT_W'(MAX_NODES)
		: CNT_W'(node_count_q);
	assign query_ok = (32'(source_q) < 32'(n_eff)) && (32'(target_node) < 32'(n_eff));
	assign load_ok = (32'(from_node) < 32'(MAX_NODES)) && (32'(to_node) < 32'(MAX_NODES));
	assign v_last = (CNT_W'(v_q) == (n_q - CNT_W'(1)));

	assign wt_waddr = {NODE_W'(from_node), NODE_W'(to_node)};
	assign wt_raddr = {u_q, v_q};

	// Relaxation of one neighbor and the running search for the next nearest node.
	always_comb begin
		sum = SUM_W'(best_q) + SUM_W'(wt_rdata_s1);
		cand = (sum > SUM_W'(DIST_MAX)) ? DIST_MAX : DIST_W'(sum);
		edge_ok = (32'(wt_rdata_s1) != 32'd0) && (32'(wt_rdata_s1) != NO_EDGE_MARK);
		open_v = vld_s1 && !done_q[v_s1];
		upd = open_v && edge_ok && (!reached_q[v_s1] || (cand < dist_rdata_s1));
		new_d = upd ? cand : dist_rdata_s1;
		new_reach = reached_q[v_s1] || upd;
		found_c = found_q;
		min_c = min_q;
		mi_c = mi_q;
		if (open_v && new_reach && (!found_q || (new_d < min_q))) begin
			found_c = 1'b1;
			min_c = new_d;
			mi_c = v_s1;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (req_valid && (op == OP_QUERY)) begin
					state_d = query_ok ? ST_INIT : ST_RESULT;
				end
			end
			ST_INIT:   state_d = ST_RELAX;
			ST_RELAX: begin
				if (v_last) begin
					state_d = ST_NEXT;
				end
			end
			ST_NEXT:   state_d = found_c ? ST_RELAX : ST_READ;
			ST_READ:   state_d = ST_LATCH;
			ST_LATCH:  state_d = ST_RESULT;
			ST_RESULT: begin
				if (!rsp_valid_q || !rsp_stall) begin
					state_d = ST_IDLE;
				end
			end
			default:   state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		req_stall = (state_q != ST_IDLE);
		accept = req_valid && (state_q == ST_IDLE);
		wt_we = accept && (op == OP_LOAD) && load_ok;
		out_load = (state_q == ST_RESULT) && (!rsp_valid_q || !rsp_stall);
		dist_raddr = (state_q == ST_READ) ? tgt_q : v_q;
		if (state_q == ST_INIT) begin
			dist_we = 1'b1;
			dist_waddr = u_q;
			dist_wdata = '0;
		end else begin
			dist_we = upd;
			dist_waddr = v_s1;
			dist_wdata = cand;
		end
	end

	always_ff @(posedge clk) begin
		if (wt_we) begin
			wt_mem[wt_waddr] <= WEIGHT_BITS'(edge_weight);
		end
		wt_rdata_s1 <= wt_mem[wt_raddr];
	end

	always_ff @(posedge clk) begin
		if (dist_we) begin
			dist_mem[dist_waddr] <= dist_wdata;
		end
		dist_rdata_s1 <= dist_mem[dist_raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			node_count_q <= NODE_COUNT_RST;
			source_q <= SOURCE_RST;
			reached_q <= '0;
			done_q <= '0;
			found_q <= 1'b0;
			vld_s1 <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			vld_s1 <= (state_q == ST_RELAX);
			if (cfg_we) begin
				case (cfg_index)
					CFG_NODE_COUNT:  node_count_q <= cfg_data;
					CFG_SOURCE_NODE: source_q <= cfg_data[NODE_FW-1:0];
					default: ;
				endcase
			end
			if (vld_s1) begin
				found_q <= found_c && (state_q != ST_NEXT);
				if (upd) begin
					reached_q[v_s1] <= 1'b1;
				end
			end
			case (state_q)
				ST_INIT: begin
					reached_q <= MAX_NODES'(1) << u_q;
					done_q <= MAX_NODES'(1) << u_q;
					found_q <= 1'b0;
				end
				ST_NEXT: begin
					if (found_c) begin
						done_q[mi_c] <= 1'b1;
					end
				end
				default: ;
			endcase
			if (out_load) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		v_s1 <= v_q;
		if (vld_s1) begin
			min_q <= min_c;
			mi_q <= mi_c;
		end
		case (state_q)
			ST_IDLE: begin
				n_q <= n_eff;
				u_q <= NODE_W'(source_q);
				tgt_q <= NODE_W'(target_node);
				res_dist_q <= '0;
				res_ok_q <= 1'b0;
			end
			ST_INIT: begin
				best_q <= '0;
				v_q <= '0;
			end
			ST_RELAX: begin
				v_q <= v_last ? '0 : v_q + NODE_W'(1);
			end
			ST_NEXT: begin
				if (found_c) begin
					u_q <= mi_c;
					best_q <= min_c;
				end
			end
			ST_LATCH: begin
				res_ok_q <= reached_q[tgt_q];
				res_dist_q <= reached_q[tgt_q] ? dist_rdata_s1 : '0;
			end
			default: ;
		endcase
		if (out_load) begin
			distance_q <= res_dist_q;
			reachable_q <= res_ok_q;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign distance = distance_q;
	assign reachable = reachable_q;

	// A settled node has always been reached first.
	a_done_reached: assert property (@(posedge clk) disable iff (!arst_n)
		(done_q & ~reached_q) == '0)
		else $error("settled node that was never reached");

	// The relaxation write never hits the entry read in the same cycle.
	a_dist_no_clash: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RELAX && dist_we) |-> (dist_waddr != dist_raddr))
		else $error("distance memory read and write collide");

	// The neighbor counter stays inside the node count in use.
	a_v_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RELAX) |-> (CNT_W'(v_q) < n_q))
		else $error("neighbor index beyond node count");

	// A result beat appears only out of the result state.
	a_rsp_origin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid_q) |-> $past(state_q == ST_RESULT))
		else $error("result beat without a finished query");

	// An unreachable target always reports a zero distance.
	a_unreach_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid_q && !reachable_q) |-> (distance_q == '0))
		else $error("unreachable target with nonzero distance");

endmodule

`default_nettype wire

>>> sim/tb_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tb_top
// Testbench of the dense graph shortest path unit. It fills the whole weight
// memory, runs directed paths and register corner settings, then random graph
// loads and distance queries under three sender and receiver idling patterns.
// A local Dijkstra search predicts each answer and every result beat is
// compared field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module tb_top;
	import dgsp_pkg::*;

	localparam int NODES          = 16;
	localparam int QUIET_LIMIT    = 5000;
	localparam int DRAIN_CYCLES   = 300;
	localparam int ITEMS_PER_MODE = 550;
	localparam int PRINT_LIMIT    = 40;

	typedef struct packed {
		logic [DIST_W-1:0] cost;
		logic              reach;
	} path_answer_t;

	logic                 clk         = 1'b0;
	logic                 arst_n      = 1'b0;
	logic                 cfg_we      = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index   = CFG_NODE_COUNT;
	logic [COUNT_FW-1:0]  cfg_data    = '0;
	logic                 req_valid   = 1'b0;
	logic                 req_stall;
	logic                 op          = OP_LOAD;
	logic [NODE_FW-1:0]   from_node   = '0;
	logic [NODE_FW-1:0]   to_node     = '0;
	logic [WEIGHT_FW-1:0] edge_weight = '0;
	logic [NODE_FW-1:0]   target_node = '0;
	logic                 rsp_valid;
	logic                 rsp_stall   = 1'b1;
	logic [DIST_W-1:0]    distance;
	logic                 reachable;

	logic [WEIGHT_FW-1:0] weight_copy [NODES][NODES];
	logic [COUNT_FW-1:0]  node_count_copy = NODE_COUNT_RST;
	logic [NODE_FW-1:0]   source_copy     = SOURCE_RST;
	path_answer_t         pending_answers [$];

	int send_gap_pct    = 18;
	int rsp_stall_pct   = 48;
	int error_count     = 0;
	int beats_sent      = 0;
	int loads_sent      = 0;
	int queries_sent    = 0;
	int answers_checked = 0;
	int settings_used   = 0;
	int quiet_cycles    = 0;

	dense_graph_shortest_path_unit dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.req_valid   (req_valid),
		.req_stall   (req_stall),
		.op          (op),
		.from_node   (from_node),
		.to_node     (to_node),
		.edge_weight (edge_weight),
		.target_node (target_node),
		.rsp_valid   (rsp_valid),
		.rsp_stall   (rsp_stall),
		.distance    (distance),
		.reachable   (reachable)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		rsp_stall <= ($urandom_range(99) < rsp_stall_pct);
	end

	always @(posedge clk) begin
		if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
	end

	initial begin
		wait (quiet_cycles >= QUIET_LIMIT);
		$display("Timeout: no beat accepted for %0d cycles.", QUIET_LIMIT);
		$display("DONE: errors detected");
		$finish;
	end

	task automatic report_mismatch(input string what, input logic [31:0] want,
			input logic [31:0] got);
		if (error_count < PRINT_LIMIT)
			$display("ERROR at %0t: %s expected %0d got %0d", $time, what, want, got);
		error_count++;
	endtask

	always @(posedge clk) begin
		path_answer_t want;
		if (arst_n && rsp_valid && !rsp_stall) begin
			answers_checked++;
			if (pending_answers.size() == 0) begin
				report_mismatch("unexpected result beat, distance", '0, 32'(distance));
			end else begin
				want = pending_answers.pop_front();
				if (distance !== want.cost)
					report_mismatch("distance", 32'(want.cost), 32'(distance));
				if (reachable !== want.reach)
					report_mismatch("reachable", 32'(want.reach), 32'(reachable));
			end
		end
	end

	function automatic path_answer_t predict_distance(input logic [NODE_FW-1:0] tgt);
		path_answer_t         ans;
		logic [DIST_W-1:0]    best [NODES];
		logic                 settled [NODES];
		logic                 seen [NODES];
		logic [DIST_W:0]      sum;
		logic [WEIGHT_FW-1:0] w;
		logic                 found;
		int                   n, u, i, v;
		ans = '0;
		n = (node_count_copy > NODES) ? NODES : int'(node_count_copy);
		if (int'(source_copy) >= n || int'(tgt) >= n)
			return ans;
		for (i = 0; i < NODES; i++) begin
			best[i] = DIST_MAX;
			settled[i] = 1'b0;
			seen[i] = 1'b0;
		end
		best[source_copy] = '0;
		seen[source_copy] = 1'b1;
		found = 1'b1;
		while (found) begin
			found = 1'b0;
			u = 0;
			for (i = 0; i < n; i++) begin
				if (!settled[i] && seen[i] && (!found || best[i] < best[u])) begin
					found = 1'b1;
					u = i;
				end
			end
			if (found) begin
				settled[u] = 1'b1;
				for (v = 0; v < n; v++) begin
					w = weight_copy[u][v];
					if (!settled[v] && w != '0 && 32'(w) != NO_EDGE_MARK) begin
						sum = {1'b0, best[u]} + (DIST_W+1)'(w);
						if (sum > (DIST_W+1)'(DIST_MAX))
							sum = (DIST_W+1)'(DIST_MAX);
						if (!seen[v] || sum[DIST_W-1:0] < best[v]) begin
							seen[v] = 1'b1;
							best[v] = sum[DIST_W-1:0];
						end
					end
				end
			end
		end
		ans.reach = seen[tgt];
		ans.cost = seen[tgt] ? best[tgt] : '0;
		return ans;
	endfunction

	function automatic logic [NODE_FW-1:0] pick_node(input int n_eff);
		if (n_eff < 2 || $urandom_range(99) < 15)
			return NODE_FW'($urandom_range(NODES - 1));
		return NODE_FW'($urandom_range(n_eff - 1));
	endfunction

	function automatic logic [WEIGHT_FW-1:0] pick_weight();
		case ($urandom_range(9))
			0, 1: return '0;
			2, 3: return WEIGHT_FW'(NO_EDGE_MARK);
			4, 5: return WEIGHT_FW'($urandom_range(60, 1));
			6: return {WEIGHT_FW{1'b1}};
			7: return WEIGHT_FW'($urandom_range(1000003, 999995));
			default: return WEIGHT_FW'($urandom);
		endcase
	endfunction

	task automatic send_beat(input logic op_v, input logic [NODE_FW-1:0] from_v,
			input logic [NODE_FW-1:0] to_v, input logic [WEIGHT_FW-1:0] w_v,
			input logic [NODE_FW-1:0] tgt_v);
		while ($urandom_range(99) < send_gap_pct) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid <= 1'b1;
		op <= op_v;
		from_node <= from_v;
		to_node <= to_v;
		edge_weight <= w_v;
		target_node <= tgt_v;
		@(posedge clk);
		while (req_stall)
			@(posedge clk);
		beats_sent++;
		if (op_v == OP_LOAD) begin
			weight_copy[from_v][to_v] = w_v;
			loads_sent++;
		end else begin
			pending_answers.push_back(predict_distance(tgt_v));
			queries_sent++;
		end
	endtask

	task automatic load_edge(input logic [NODE_FW-1:0] from_v, input logic [NODE_FW-1:0] to_v,
			input logic [WEIGHT_FW-1:0] w_v);
		send_beat(OP_LOAD, from_v, to_v, w_v, NODE_FW'($urandom_range(NODES - 1)));
	endtask

	task automatic query_node(input logic [NODE_FW-1:0] tgt_v);
		send_beat(OP_QUERY, NODE_FW'($urandom_range(NODES - 1)),
			NODE_FW'($urandom_range(NODES - 1)), WEIGHT_FW'($urandom), tgt_v);
	endtask

	task automatic wait_for_answers(input int settle);
		req_valid <= 1'b0;
		while (pending_answers.size() != 0)
			@(posedge clk);
		repeat (settle) @(posedge clk);
	endtask

	task automatic write_config(input logic [COUNT_FW-1:0] cnt, input logic [COUNT_FW-1:0] src_word);
		wait_for_answers(4);
		cfg_we <= 1'b1;
		cfg_index <= CFG_NODE_COUNT;
		cfg_data <= cnt;
		@(posedge clk);
		node_count_copy = cnt;
		cfg_index <= CFG_SOURCE_NODE;
		cfg_data <= src_word;
		@(posedge clk);
		source_copy = src_word[NODE_FW-1:0];
		cfg_we <= 1'b0;
		settings_used++;
	endtask

	task automatic test_fill_weights();
		int f, t;
		for (f = 0; f < NODES; f++)
			for (t = 0; t < NODES; t++)
				load_edge(NODE_FW'(f), NODE_FW'(t), '0);
	endtask

	task automatic test_directed_paths();
		int i;
		query_node(4'd0);
		query_node(4'd5);
		load_edge(4'd0, 4'd1, WEIGHT_FW'(NO_EDGE_MARK));
		query_node(4'd1);
		load_edge(4'd0, 4'd1, 20'd7);
		query_node(4'd1);
		for (i = 1; i < NODES - 1; i++)
			load_edge(NODE_FW'(i), NODE_FW'(i + 1), {WEIGHT_FW{1'b1}});
		query_node(4'd15);
		load_edge(4'd0, 4'd15, 20'd20);
		query_node(4'd15);
	endtask

	task automatic test_config_extremes();
		write_config(5'd0, 5'd0);
		query_node(4'd0);
		write_config(5'd1, 5'd0);
		query_node(4'd0);
		query_node(4'd1);
		write_config(5'd31, 5'h1F);
		query_node(4'd15);
		query_node(4'd0);
		write_config(5'd17, 5'd3);
		query_node(4'd15);
		write_config(5'd2, 5'd15);
		query_node(4'd0);
		write_config(5'd2, 5'd0);
		query_node(4'd1);
		query_node(4'd15);
		write_config(NODE_COUNT_RST, 5'd16);
		query_node(4'd15);
	endtask

	task automatic test_random_traffic(input int gap_pct, input int stall_pct);
		logic [COUNT_FW-1:0] cnt;
		logic [COUNT_FW-1:0] src_word;
		int                  sent, phase_len, k, n_eff;
		send_gap_pct = gap_pct;
		rsp_stall_pct = stall_pct;
		sent = 0;
		while (sent < ITEMS_PER_MODE) begin
			case ($urandom_range(9))
				0: cnt = COUNT_FW'($urandom_range(1));
				1: cnt = COUNT_FW'($urandom_range(31, 17));
				2: cnt = NODE_COUNT_RST;
				default: cnt = COUNT_FW'($urandom_range(16, 2));
			endcase
			n_eff = (cnt > NODES) ? NODES : int'(cnt);
			src_word = COUNT_FW'($urandom_range(31));
			if (n_eff > 0 && $urandom_range(9) != 0)
				src_word[NODE_FW-1:0] = NODE_FW'($urandom_range(n_eff - 1));
			write_config(cnt, src_word);
			phase_len = $urandom_range(70, 30);
			k = 0;
			while (k < phase_len) begin
				repeat ($urandom_range(6, 1)) begin
					load_edge(pick_node(n_eff), pick_node(n_eff), pick_weight());
					k++;
				end
				repeat ($urandom_range(3, 1)) begin
					query_node(pick_node(n_eff));
					k++;
				end
			end
			sent += k;
		end
	endtask

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_fill_weights();
		test_directed_paths();
		test_config_extremes();
		test_random_traffic(18, 48);
		test_random_traffic(48, 18);
		test_random_traffic(0, 0);
		wait_for_answers(DRAIN_CYCLES);
		$display("Summary: %0d beats sent, %0d weight loads and %0d distance queries.",
			beats_sent, loads_sent, queries_sent);
		$display("Summary: %0d result beats checked over %0d register settings.",
			answers_checked, settings_used);
		if (error_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

`default_nettype wire
